/* sv/hspd_pkg.sv */
`default_nettype none

package hspd_pkg;

    // Fixed field widths of the ports
    localparam int unsigned POSITION_PORT_BITS    = 16;
    localparam int unsigned REVOLUTION_PORT_BITS  = 32;
    localparam int unsigned CPR_BITS              = 16;
    localparam int unsigned CFG_INDEX_BITS        = 1;
    localparam int unsigned CFG_DATA_BITS         = 16;
    localparam int unsigned PINS_BITS             = 3;

    localparam logic [CPR_BITS-1:0] CPR_RESET = 16'd6;

    typedef logic [CFG_INDEX_BITS-1:0] t_cfg_index;
    localparam t_cfg_index CFG_CPR      = 1'b0;
    localparam t_cfg_index CFG_INVERTED = 1'b1;

    typedef logic [PINS_BITS-1:0] t_pins;
    localparam t_pins PINS_NONE = 3'b000;
    localparam t_pins PINS_ALL  = 3'b111;

    typedef logic signed [1:0] t_dir;
    localparam t_dir DIR_NONE = 2'sb00;
    localparam t_dir DIR_POS  = 2'sb01;
    localparam t_dir DIR_NEG  = 2'sb11;

    localparam logic MODE_COUNT  = 1'b0;
    localparam logic MODE_RESYNC = 1'b1;

    // Inputs of the step logic taken from the request, the config and the last pattern
    typedef struct packed {
        logic  mode;
        t_pins pins;
        t_pins last_pattern;
        logic  inverted;
    } t_step_ctrl;

    // Status produced by the step logic
    typedef struct packed {
        logic pattern_valid;
        logic count;
        logic changed;
        t_dir direction;
    } t_step_stat;

    // Successor along the positive cycle: 001 011 010 110 100 101
    function automatic t_pins fwd_next(input t_pins p);
        t_pins n;
        case (p)
            3'd1:    n = 3'd3;
            3'd2:    n = 3'd6;
            3'd3:    n = 3'd2;
            3'd4:    n = 3'd5;
            3'd5:    n = 3'd1;
            3'd6:    n = 3'd4;
            default: n = PINS_NONE;
        endcase
        return n;
    endfunction

    function automatic t_dir step_of(input t_pins from_p, input t_pins to_p);
        t_pins nf;
        t_pins nt;
        t_dir  d;
        nf = fwd_next(from_p);
        nt = fwd_next(to_p);
        if (nf != PINS_NONE && nf == to_p) begin
            d = DIR_POS;
        end else if (nt != PINS_NONE && nt == from_p) begin
            d = DIR_NEG;
        end else begin
            d = DIR_NONE;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

/* sv/hspd_step.sv */
`default_nettype none

module hspd_step #(
    parameter int unsigned POSITION_BITS   = 16,
    parameter int unsigned REVOLUTION_BITS = 32
) (
    input  wire hspd_pkg::t_step_ctrl          i_ctrl,
    input  wire [hspd_pkg::CPR_BITS-1:0]       i_cpr,
    input  wire [POSITION_BITS-1:0]            i_position,
    input  wire [REVOLUTION_BITS-1:0]          i_revolutions,
    input  wire hspd_pkg::t_dir                i_direction,
    output logic [POSITION_BITS-1:0]           o_position,
    output logic [REVOLUTION_BITS-1:0]         o_revolutions,
    output hspd_pkg::t_step_stat               o_stat
);

    localparam int unsigned WIDE_BITS =
        ((POSITION_BITS > hspd_pkg::CPR_BITS) ? POSITION_BITS : hspd_pkg::CPR_BITS) + 1;

    hspd_pkg::t_dir       step_dir;
    logic                 count;
    logic                 up;
    logic [WIDE_BITS-1:0] modulus;
    logic [WIDE_BITS-1:0] pos_wide;
    logic [WIDE_BITS-1:0] inc;
    logic                 wrap_up;
    logic                 wrap_dn;
    logic [WIDE_BITS-1:0] up_val;
    logic [WIDE_BITS-1:0] dn_val;

    always_comb begin
        step_dir = hspd_pkg::step_of(i_ctrl.last_pattern, i_ctrl.pins);
        count    = (i_ctrl.mode == hspd_pkg::MODE_COUNT) &&
                   (i_ctrl.pins != i_ctrl.last_pattern) &&
                   (step_dir != hspd_pkg::DIR_NONE);
        up       = (step_dir == hspd_pkg::DIR_POS) ^ i_ctrl.inverted;

        // cpr of zero wraps through the full position width
        modulus  = (i_cpr == '0) ? (WIDE_BITS'(1) << POSITION_BITS) : WIDE_BITS'(i_cpr);
        pos_wide = WIDE_BITS'(i_position);
        inc      = pos_wide + WIDE_BITS'(1);
        wrap_up  = (inc >= modulus);
        up_val   = wrap_up ? (inc - modulus) : inc;
        wrap_dn  = (i_position == '0);
        dn_val   = wrap_dn ? (modulus - WIDE_BITS'(1)) : (pos_wide - WIDE_BITS'(1));

        o_position    = i_position;
        o_revolutions = i_revolutions;
        if (count) begin
            o_position = up ? up_val[POSITION_BITS-1:0] : dn_val[POSITION_BITS-1:0];
            if (up && wrap_up) begin
                o_revolutions = i_revolutions + REVOLUTION_BITS'(1);
            end else if (!up && wrap_dn) begin
                o_revolutions = i_revolutions - REVOLUTION_BITS'(1);
            end
        end

        o_stat.pattern_valid = !(i_ctrl.pins inside {hspd_pkg::PINS_NONE,
                                                     hspd_pkg::PINS_ALL});
        o_stat.count         = count;
        o_stat.changed       = (o_position != i_position);
        o_stat.direction     = count ? step_dir : i_direction;
    end

endmodule

`default_nettype wire

/* sv/hall_sensor_position_decoder_unit.sv */
`default_nettype none

// Hall sensor position decoder. Each request carries one sample of the three
// Hall levels; the block tracks the six-step cycle and keeps a position that
// wraps at cpr plus a signed revolution count. One request is taken every
// clock cycle unless the result side stalls; its result passes through the
// input register, then the step logic that updates the counters and loads
// the result register. The state update is two table lookups, an add, a
// subtract and a compare, so throughput is limited only by output stall. Config
// writes are always ready and must only be issued while the block is idle.
module hall_sensor_position_decoder_unit #(
    parameter int unsigned POSITION_BITS   = 16,
    parameter int unsigned REVOLUTION_BITS = 32
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    // sample channel
    input  wire                                      i_valid,
    output logic                                     o_stall,
    input  wire                                      i_mode,
    input  wire [hspd_pkg::PINS_BITS-1:0]            i_hall_pins,
    // result channel
    output logic                                     o_valid,
    input  wire                                      i_stall,
    output logic [hspd_pkg::POSITION_PORT_BITS-1:0]  o_position,
    output logic [hspd_pkg::REVOLUTION_PORT_BITS-1:0] o_revolutions,
    output logic signed [1:0]                        o_direction,
    output logic                                     o_pattern_valid,
    output logic                                     o_changed,
    // config channel
    input  wire                                      i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire [hspd_pkg::CFG_INDEX_BITS-1:0]       i_cfg_index,
    input  wire [hspd_pkg::CFG_DATA_BITS-1:0]        i_cfg_data
);

    localparam int unsigned POS_EXT_BITS =
        (POSITION_BITS > hspd_pkg::POSITION_PORT_BITS) ? POSITION_BITS
                                                       : hspd_pkg::POSITION_PORT_BITS;
    localparam int unsigned REV_EXT_BITS =
        (REVOLUTION_BITS > hspd_pkg::REVOLUTION_PORT_BITS) ? REVOLUTION_BITS
                                                           : hspd_pkg::REVOLUTION_PORT_BITS;

    logic [hspd_pkg::CPR_BITS-1:0] r_cpr;
    logic                          r_inverted;

    logic                          r_in_valid;
    logic                          r_mode;
    hspd_pkg::t_pins               r_pins;

    hspd_pkg::t_pins               r_last_pattern;
    logic [POSITION_BITS-1:0]      r_position;
    logic [REVOLUTION_BITS-1:0]    r_revolutions;
    hspd_pkg::t_dir                r_direction;

    logic                          r_out_valid;
    logic                          r_pattern_valid;
    logic                          r_changed;

    logic                          advance;
    hspd_pkg::t_step_ctrl          step_ctrl;
    hspd_pkg::t_step_stat          step_stat;
    logic [POSITION_BITS-1:0]      n_position;
    logic [REVOLUTION_BITS-1:0]    n_revolutions;
    logic [POS_EXT_BITS-1:0]       pos_ext;
    logic [REV_EXT_BITS-1:0]       rev_ext;

    assign advance     = !(r_out_valid && i_stall);
    assign o_stall     = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr      <= hspd_pkg::CPR_RESET;
            r_inverted <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                hspd_pkg::CFG_CPR:      r_cpr      <= i_cfg_data;
                hspd_pkg::CFG_INVERTED: r_inverted <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_mode <= i_mode;
            r_pins <= i_hall_pins;
        end
    end

    always_comb begin
        step_ctrl.mode         = r_mode;
        step_ctrl.pins         = r_pins;
        step_ctrl.last_pattern = r_last_pattern;
        step_ctrl.inverted     = r_inverted;
    end

    hspd_step #(
        .POSITION_BITS   (POSITION_BITS),
        .REVOLUTION_BITS (REVOLUTION_BITS)
    ) u_step (
        .i_ctrl        (step_ctrl),
        .i_cpr         (r_cpr),
        .i_position    (r_position),
        .i_revolutions (r_revolutions),
        .i_direction   (r_direction),
        .o_position    (n_position),
        .o_revolutions (n_revolutions),
        .o_stat        (step_stat)
    );

    // counter state doubles as the result payload; it only moves on advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_last_pattern <= hspd_pkg::PINS_NONE;
            r_position     <= '0;
            r_revolutions  <= '0;
            r_direction    <= hspd_pkg::DIR_NONE;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_last_pattern <= r_pins;
                r_position     <= n_position;
                r_revolutions  <= n_revolutions;
                r_direction    <= step_stat.direction;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_pattern_valid <= step_stat.pattern_valid;
            r_changed       <= step_stat.changed;
        end
    end

    assign pos_ext         = POS_EXT_BITS'(r_position);
    assign rev_ext         = REV_EXT_BITS'(r_revolutions);
    assign o_valid         = r_out_valid;
    assign o_position      = pos_ext[hspd_pkg::POSITION_PORT_BITS-1:0];
    assign o_revolutions   = rev_ext[hspd_pkg::REVOLUTION_PORT_BITS-1:0];
    assign o_direction     = r_direction;
    assign o_pattern_valid = r_pattern_valid;
    assign o_changed       = r_changed;

    a_changed_moves_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid && step_stat.changed) |=> (r_position != $past(r_position)))
        else $error("changed flag set but position held");

    a_changed_needs_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_stat.changed |-> (step_stat.count && (r_mode == hspd_pkg::MODE_COUNT)))
        else $error("position changed without a legal count step");

    a_direction_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_direction == hspd_pkg::DIR_NONE) || (r_direction == hspd_pkg::DIR_POS) ||
        (r_direction == hspd_pkg::DIR_NEG))
        else $error("direction register holds an unused code");

    a_state_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> ($stable(r_position) && $stable(r_revolutions) &&
                                      $stable(r_last_pattern)))
        else $error("counter state moved while the result was stalled");

endmodule

`default_nettype wire

/* tb/sv/hall_position_monitor.sv */
`timescale 1ns / 1ps

module hall_position_monitor (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  wire         o_stall,
    input  wire         i_mode,
    input  wire hspd_pkg::t_pins  i_hall_pins,
    input  wire         o_valid,
    input  wire         i_stall,
    input  wire [15:0]  o_position,
    input  wire [31:0]  o_revolutions,
    input  wire hspd_pkg::t_dir   o_direction,
    input  wire         o_pattern_valid,
    input  wire         o_changed,
    input  wire         i_cfg_valid,
    input  wire         o_cfg_ready,
    input  wire hspd_pkg::t_cfg_index i_cfg_index,
    input  wire [15:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0]    position;
        logic [31:0]    revolutions;
        hspd_pkg::t_dir direction;
        logic           pattern_valid;
        logic           changed;
    } t_reading;

    // Positive six-step order of the sensor patterns
    localparam hspd_pkg::t_pins RING [0:5] =
        '{3'b001, 3'b011, 3'b010, 3'b110, 3'b100, 3'b101};

    logic [15:0]     cpr_q;
    logic            inv_q;
    hspd_pkg::t_pins pat_q;
    logic [15:0]     pos_q;
    logic [31:0]     rev_q;
    hspd_pkg::t_dir  dir_q;
    t_reading        expected_readings [$];
    int              mismatches;

    function automatic int ring_slot(input hspd_pkg::t_pins p);
        for (int i = 0; i < 6; i++) begin
            if (RING[i] == p) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic hspd_pkg::t_dir cycle_step(input hspd_pkg::t_pins from_p,
                                                  input hspd_pkg::t_pins to_p);
        int a;
        int b;
        a = ring_slot(from_p);
        b = ring_slot(to_p);
        if (a < 0 || b < 0) begin
            return hspd_pkg::DIR_NONE;
        end
        if ((a + 1) % 6 == b) begin
            return hspd_pkg::DIR_POS;
        end
        if ((b + 1) % 6 == a) begin
            return hspd_pkg::DIR_NEG;
        end
        return hspd_pkg::DIR_NONE;
    endfunction

    task automatic advance_position(input logic mode, input hspd_pkg::t_pins pins,
                                    output t_reading r);
        hspd_pkg::t_dir d;
        logic [16:0]    modulus;
        logic [16:0]    p;
        logic [15:0]    prior;
        prior   = pos_q;
        modulus = (cpr_q == 16'd0) ? 17'h10000 : {1'b0, cpr_q};
        d = (mode == hspd_pkg::MODE_COUNT && pins != pat_q) ? cycle_step(pat_q, pins)
                                                            : hspd_pkg::DIR_NONE;
        pat_q = pins;
        if (d != hspd_pkg::DIR_NONE) begin
            dir_q = d;
            p = {1'b0, pos_q};
            // inversion flips which way a legal step moves the count
            if ((d == hspd_pkg::DIR_POS) != inv_q) begin
                p = p + 17'd1;
                if (p >= modulus) begin
                    p = p - modulus;
                    rev_q = rev_q + 32'd1;
                end
            end else begin
                if (p == 17'd0) begin
                    p = modulus - 17'd1;
                    rev_q = rev_q - 32'd1;
                end else begin
                    p = p - 17'd1;
                end
            end
            pos_q = p[15:0];
        end
        r.position      = pos_q;
        r.revolutions   = rev_q;
        r.direction     = dir_q;
        r.pattern_valid = (pins != hspd_pkg::PINS_NONE && pins != hspd_pkg::PINS_ALL);
        r.changed       = (pos_q != prior);
    endtask

    always @(posedge i_clk) begin
        t_reading want;
        t_reading seen;
        if (!i_rst_n) begin
            cpr_q      = hspd_pkg::CPR_RESET;
            inv_q      = 1'b0;
            pat_q      = hspd_pkg::PINS_NONE;
            pos_q      = '0;
            rev_q      = '0;
            dir_q      = hspd_pkg::DIR_NONE;
            mismatches = 0;
            expected_readings.delete();
        end else begin
            if (o_valid && !i_stall) begin
                seen = '{o_position, o_revolutions, o_direction, o_pattern_valid, o_changed};
                if (expected_readings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result pos=%0d rev=%0d dir=%0d pv=%0b ch=%0b",
                                 $realtime, seen.position, $signed(seen.revolutions),
                                 seen.direction, seen.pattern_valid, seen.changed);
                    end
                end else begin
                    want = expected_readings.pop_front();
                    if (want.position !== seen.position ||
                        want.revolutions !== seen.revolutions ||
                        want.direction !== seen.direction ||
                        want.pattern_valid !== seen.pattern_valid ||
                        want.changed !== seen.changed) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch exp pos=%0d rev=%0d dir=%0d pv=%0b ch=%0b",
                                     $realtime, want.position, $signed(want.revolutions),
                                     want.direction, want.pattern_valid, want.changed);
                            $display("%0t:          got pos=%0d rev=%0d dir=%0d pv=%0b ch=%0b",
                                     $realtime, seen.position, $signed(seen.revolutions),
                                     seen.direction, seen.pattern_valid, seen.changed);
                        end
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    hspd_pkg::CFG_CPR:      cpr_q = i_cfg_data;
                    hspd_pkg::CFG_INVERTED: inv_q = i_cfg_data[0];
                    default:                ;
                endcase
            end
            if (i_valid && !o_stall) begin
                advance_position(i_mode, i_hall_pins, want);
                expected_readings.push_back(want);
            end
        end
        o_pending    <= expected_readings.size();
        o_fail_count <= mismatches;
    end

endmodule

/* tb/sv/tb_hall_sensor_position_decoder_unit.sv */
`timescale 1ns / 1ps

module tb_hall_sensor_position_decoder_unit;

    localparam int CYCLE_LIMIT = 400000;
    localparam hspd_pkg::t_pins CYCLE [0:5] =
        '{3'b001, 3'b011, 3'b010, 3'b110, 3'b100, 3'b101};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 i_mode = hspd_pkg::MODE_COUNT;
    hspd_pkg::t_pins      i_hall_pins = hspd_pkg::PINS_NONE;
    logic                 i_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    hspd_pkg::t_cfg_index i_cfg_index = hspd_pkg::CFG_CPR;
    logic [15:0]          i_cfg_data = 16'd0;

    wire            o_stall;
    wire            o_valid;
    wire [15:0]     o_position;
    wire [31:0]     o_revolutions;
    hspd_pkg::t_dir o_direction;
    wire            o_pattern_valid;
    wire            o_changed;
    wire            o_cfg_ready;

    int              fail_count;
    int              pending_count;
    int              cycles = 0;
    logic            quiet = 1'b0;
    int              gap_pct = 10;
    int              walk_dir = 1;
    hspd_pkg::t_pins sent_pins = hspd_pkg::PINS_NONE;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    hall_sensor_position_decoder_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_hall_pins     (i_hall_pins),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_position      (o_position),
        .o_revolutions   (o_revolutions),
        .o_direction     (o_direction),
        .o_pattern_valid (o_pattern_valid),
        .o_changed       (o_changed),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    hall_position_monitor u_monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_hall_pins     (i_hall_pins),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_position      (o_position),
        .o_revolutions   (o_revolutions),
        .o_direction     (o_direction),
        .o_pattern_valid (o_pattern_valid),
        .o_changed       (o_changed),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** hall_sensor_position_decoder_unit: FAILED **");
            $finish;
        end
    end

    // Result side backpressure in bursts, with long free stretches
    initial begin
        forever begin
            if (quiet) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(20, 120)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    function automatic int find_slot(input hspd_pkg::t_pins p);
        for (int i = 0; i < 6; i++) begin
            if (CYCLE[i] == p) begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic send_sample(input logic mode, input hspd_pkg::t_pins pins);
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_hall_pins <= pins;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_pins = pins;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // Hold off new requests until every result is back
    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input hspd_pkg::t_cfg_index idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] cpr, input logic inv);
        drain();
        write_reg(hspd_pkg::CFG_CPR, cpr);
        write_reg(hspd_pkg::CFG_INVERTED, {15'd0, inv});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic walk(input int dir, input int n);
        repeat (n) begin
            send_sample(hspd_pkg::MODE_COUNT, CYCLE[(find_slot(sent_pins) + 6 + dir) % 6]);
        end
    endtask

    task automatic random_sample;
        int k;
        int slot;
        k = $urandom_range(0, 99);
        if (k < 72) begin
            slot = find_slot(sent_pins);
            if (slot < 0) begin
                send_sample(hspd_pkg::MODE_COUNT, CYCLE[$urandom_range(0, 5)]);
            end else begin
                if ($urandom_range(0, 15) == 0) begin
                    walk_dir = -walk_dir;
                end
                send_sample(hspd_pkg::MODE_COUNT, CYCLE[(slot + 6 + walk_dir) % 6]);
            end
        end else if (k < 80) begin
            send_sample(hspd_pkg::MODE_COUNT, sent_pins);
        end else if (k < 88) begin
            send_sample(hspd_pkg::MODE_RESYNC, hspd_pkg::t_pins'($urandom_range(0, 7)));
        end else if (k < 94) begin
            send_sample(hspd_pkg::MODE_COUNT, hspd_pkg::t_pins'($urandom_range(0, 7)));
        end else begin
            send_sample(hspd_pkg::MODE_COUNT,
                        $urandom_range(0, 1) ? hspd_pkg::PINS_ALL : hspd_pkg::PINS_NONE);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: wrap both ways, repeats, resync, invalid and illegal jumps
        send_sample(hspd_pkg::MODE_COUNT, 3'b001);
        walk(1, 6);
        send_sample(hspd_pkg::MODE_COUNT, sent_pins);
        walk(-1, 2);
        send_sample(hspd_pkg::MODE_COUNT, 3'b001);
        send_sample(hspd_pkg::MODE_RESYNC, 3'b100);
        send_sample(hspd_pkg::MODE_COUNT, 3'b101);
        send_sample(hspd_pkg::MODE_COUNT, hspd_pkg::PINS_ALL);
        send_sample(hspd_pkg::MODE_COUNT, hspd_pkg::PINS_NONE);
        send_sample(hspd_pkg::MODE_RESYNC, hspd_pkg::PINS_ALL);
        send_sample(hspd_pkg::MODE_COUNT, 3'b001);
        // full-width wrap, then lower cpr below the position
        configure(16'd0, 1'b1);
        walk(1, 6);
        configure(16'd6, 1'b0);
        walk(1, 2);
        walk(-1, 2);
        configure(16'd1, 1'b1);
        walk(-1, 2);
        configure(16'hFFFF, 1'b0);
        walk(-1, 1);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: configure(16'd6, 1'b0);
                1: configure(16'd1, 1'b1);
                2: configure(16'd0, 1'b0);
                3: configure(16'hFFFF, 1'b1);
                4: configure(16'($urandom_range(2, 12)), 1'($urandom_range(0, 1)));
                5: configure(16'd3, 1'b1);
                6: configure(16'($urandom_range(1, 40)), 1'($urandom_range(0, 1)));
                default: configure(16'd5, 1'b0);
            endcase
            walk_dir = $urandom_range(0, 1) ? 1 : -1;
            gap_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 25);
            if (ph == 7) begin
                quiet = 1'b1;
            end
            for (int n = 0; n < 200; n++) begin
                if (ph == 2 && n == 100) begin
                    drain();
                end
                random_sample();
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("** hall_sensor_position_decoder_unit: PASSED **");
        end else begin
            $display("** hall_sensor_position_decoder_unit: FAILED **");
        end
        $finish;
    end

endmodule
